// ===== rtl/tpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfd_pkg
// Shared types and constants of the timecode pulse frame decoder.
// ----------------------------------------------------------------------------
package tpfd_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_ERROR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_ENABLE   = 3'd6;

  localparam logic [7:0] RST_SYNC_GAP_MIN = 8'd104;
  localparam logic [7:0] RST_ZERO_MIN     = 8'd3;
  localparam logic [7:0] RST_ZERO_MAX     = 8'd5;
  localparam logic [7:0] RST_ONE_MIN      = 8'd7;
  localparam logic [7:0] RST_ONE_MAX      = 8'd9;
  localparam logic [7:0] RST_LONG_ERROR   = 8'd120;

  localparam logic [5:0] FRAME_LEN = 6'd59;
  localparam logic [5:0] MAX_COUNT = 6'd60;

  localparam logic [2:0] ST_NO_SYNC   = 3'd0;
  localparam logic [2:0] ST_BAD_COUNT = 3'd1;
  localparam logic [2:0] ST_REJECTED  = 3'd2;
  localparam logic [2:0] ST_GOOD      = 3'd3;
  localparam logic [2:0] ST_CONFIRMED = 3'd4;

  localparam logic [7:0] BCD_WEIGHT [8] = '{8'd1, 8'd2, 8'd4, 8'd8,
                                            8'd10, 8'd20, 8'd40, 8'd80};

  typedef enum logic [1:0] {
    CLS_CLEAR,
    CLS_ZERO,
    CLS_ONE,
    CLS_IGNORE
  } cls_t;

  typedef struct packed {
    logic sync;
    cls_t cls;
    logic set_en;
  } cmd_t;

  typedef struct packed {
    logic [2:0] frame_status;
    logic       set_time;
    logic [6:0] minute;
    logic [5:0] hour;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
    logic [5:0] bits_gathered;
  } res_t;

  function automatic logic [7:0] bcd_sum(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    for (int i = 0; i < 8; i++) begin
      v = v + (b[i] ? BCD_WEIGHT[i] : 8'd0);
    end
    return v;
  endfunction

endpackage

// ===== rtl/timecode_pulse_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// timecode_pulse_frame_decoder
// Minute-frame decoder for a pulse-width time signal: classifies pulses,
// gathers frame bits, checks and decodes the frame at each minute mark.
//
//   channel   ports                              handshake
//   input     in_pulse_ticks, in_gap_ticks       push / full
//   result    out_frame_status .. out_bits_gathered  empty / pop
//   config    cfg_index, cfg_data                cfg_we, no wait
//
// One beat per cycle sustained while results are popped; a result reaches the
// out ports once its pulse beat has been registered in the command queue and
// then in the result queue (classifier into a 2-entry command queue, frame
// engine into a 2-entry result queue). The frame engine is the one serial point:
// it updates the frame store once per beat. A stalled pop backs up the result
// queue, then the command queue, then raises full. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module timecode_pulse_frame_decoder #(
  parameter int FRAME_STORE_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      in_pulse_ticks,
  input  logic [7:0]                      in_gap_ticks,
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      out_frame_status,
  output logic                            out_set_time,
  output logic [6:0]                      out_minute_out,
  output logic [5:0]                      out_hour_out,
  output logic [5:0]                      out_day_out,
  output logic [4:0]                      out_month_out,
  output logic [7:0]                      out_year_out,
  output logic [5:0]                      out_bits_gathered,
  input  logic                            cfg_we,
  input  logic [tpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpfd_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic cmd_empty, cmd_pop;
  res_t back_res, out_res;
  logic res_full, res_push;

  tpfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pulse_ticks(in_pulse_ticks),
    .gap_ticks  (in_gap_ticks),
    .cmd        (front_cmd)
  );

  tpfd_queue #(.WIDTH($bits(cmd_t))) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(front_cmd),
    .full (full),
    .pop  (cmd_pop),
    .empty(cmd_empty),
    .rdata(back_cmd)
  );

  tpfd_back #(.FRAME_STORE_BITS(FRAME_STORE_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(~cmd_empty),
    .cmd      (back_cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  tpfd_queue #(.WIDTH($bits(res_t))) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(back_res),
    .full (res_full),
    .pop  (pop),
    .empty(empty),
    .rdata(out_res)
  );

  assign out_frame_status  = out_res.frame_status;
  assign out_set_time      = out_res.set_time;
  assign out_minute_out    = out_res.minute;
  assign out_hour_out      = out_res.hour;
  assign out_day_out       = out_res.day;
  assign out_month_out     = out_res.month;
  assign out_year_out      = out_res.year;
  assign out_bits_gathered = out_res.bits_gathered;

endmodule

// ===== rtl/tpfd_queue.sv =====
// ----------------------------------------------------------------------------
// tpfd_queue
// Short register queue; decouples the stages on either side of it.
// ----------------------------------------------------------------------------
module tpfd_queue #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  import tpfd_pkg::*;

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> !empty)
    else $error("queue empty after a pushed beat");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !push) |=> !full)
    else $error("queue full after a popped beat");

endmodule

// ===== rtl/tpfd_front.sv =====
// ----------------------------------------------------------------------------
// tpfd_front
// Configuration registers and pulse classifier: turns each accepted pulse
// into a sync flag, a bit class and the set-enable flag.
// ----------------------------------------------------------------------------
module tpfd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                    pulse_ticks,
  input  logic [7:0]                    gap_ticks,
  output tpfd_pkg::cmd_t                cmd
);
  import tpfd_pkg::*;

  logic [7:0] sync_gap_min_r, zero_min_r, zero_max_r;
  logic [7:0] one_min_r, one_max_r, long_error_r;
  logic       set_enable_r;
  cls_t       cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_gap_min_r <= RST_SYNC_GAP_MIN;
      zero_min_r     <= RST_ZERO_MIN;
      zero_max_r     <= RST_ZERO_MAX;
      one_min_r      <= RST_ONE_MIN;
      one_max_r      <= RST_ONE_MAX;
      long_error_r   <= RST_LONG_ERROR;
      set_enable_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_GAP_MIN: sync_gap_min_r <= cfg_data;
        CFG_ZERO_MIN:     zero_min_r     <= cfg_data;
        CFG_ZERO_MAX:     zero_max_r     <= cfg_data;
        CFG_ONE_MIN:      one_min_r      <= cfg_data;
        CFG_ONE_MAX:      one_max_r      <= cfg_data;
        CFG_LONG_ERROR:   long_error_r   <= cfg_data;
        CFG_SET_ENABLE:   set_enable_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // range checks in fixed order; overlapping ranges resolve to the earlier one
  always_comb begin
    priority if (pulse_ticks < zero_min_r) begin
      cls = CLS_CLEAR;
    end else if (pulse_ticks <= zero_max_r) begin
      cls = CLS_ZERO;
    end else if (pulse_ticks >= one_min_r && pulse_ticks <= one_max_r) begin
      cls = CLS_ONE;
    end else if (pulse_ticks > long_error_r) begin
      cls = CLS_CLEAR;
    end else begin
      cls = CLS_IGNORE;
    end
  end

  assign cmd.sync   = (gap_ticks > sync_gap_min_r);
  assign cmd.cls    = cls;
  assign cmd.set_en = set_enable_r;

endmodule

// ===== rtl/tpfd_back.sv =====
// ----------------------------------------------------------------------------
// tpfd_back
// Frame engine: holds the gathered bits, checks and decodes a frame at each
// minute mark, and emits one result per classified pulse.
// ----------------------------------------------------------------------------
module tpfd_back #(
  parameter int FRAME_STORE_BITS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  tpfd_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output tpfd_pkg::res_t res
);
  import tpfd_pkg::*;

  localparam int IDX_W = $clog2(FRAME_STORE_BITS);

  logic [FRAME_STORE_BITS-1:0] frame_bits_r, frame_bits_nxt;
  logic [5:0] bit_count_r, bit_count_nxt;
  logic [5:0] last_hour_r, last_hour_nxt;
  logic [5:0] last_day_r, last_day_nxt;
  logic [4:0] last_month_r, last_month_nxt;
  logic [7:0] last_year_r, last_year_nxt;

  logic       go;
  logic [7:0] mi_w, hr_w, dy_w, mo_w, yr_w;
  logic       frame_ok, same_date;
  logic [5:0] cnt_base, cnt_inc, cnt_new;

  assign go       = cmd_valid & ~res_full;
  assign cmd_pop  = go;
  assign res_push = go;

  assign mi_w = bcd_sum({1'b0, frame_bits_r[27:21]});
  assign hr_w = bcd_sum({2'b00, frame_bits_r[34:29]});
  assign dy_w = bcd_sum({2'b00, frame_bits_r[41:36]});
  assign mo_w = bcd_sum({3'b000, frame_bits_r[49:45]});
  assign yr_w = bcd_sum(frame_bits_r[57:50]);

  assign frame_ok = !frame_bits_r[0] && frame_bits_r[20] &&
                    !(^frame_bits_r[28:21]) && !(^frame_bits_r[35:29]) &&
                    !(^frame_bits_r[58:36]) &&
                    (frame_bits_r[17] != frame_bits_r[18]);

  assign same_date = (last_hour_r == hr_w[5:0]) && (last_day_r == dy_w[5:0]) &&
                     (last_month_r == mo_w[4:0]) && (last_year_r == yr_w);

  assign cnt_base = cmd.sync ? 6'd0 : bit_count_r;
  assign cnt_inc  = cnt_base + 6'd1;

  always_comb begin
    res            = '0;
    res.frame_status = ST_NO_SYNC;
    last_hour_nxt  = last_hour_r;
    last_day_nxt   = last_day_r;
    last_month_nxt = last_month_r;
    last_year_nxt  = last_year_r;
    frame_bits_nxt = frame_bits_r;
    cnt_new        = cnt_base;

    if (cmd.sync) begin
      res.frame_status = ST_BAD_COUNT;
      if (bit_count_r == FRAME_LEN) begin
        res.minute = mi_w[6:0];
        res.hour   = hr_w[5:0];
        res.day    = dy_w[5:0];
        res.month  = mo_w[4:0];
        res.year   = yr_w;
        if (frame_ok) begin
          res.frame_status = same_date ? ST_CONFIRMED : ST_GOOD;
          res.set_time     = same_date & cmd.set_en;
          last_hour_nxt    = hr_w[5:0];
          last_day_nxt     = dy_w[5:0];
          last_month_nxt   = mo_w[4:0];
          last_year_nxt    = yr_w;
        end else begin
          res.frame_status = ST_REJECTED;
        end
      end
    end

    unique case (cmd.cls)
      CLS_CLEAR: cnt_new = 6'd0;
      CLS_ZERO: begin
        if (32'(cnt_base) < FRAME_STORE_BITS) begin
          frame_bits_nxt[cnt_base[IDX_W-1:0]] = 1'b0;
        end
        cnt_new = cnt_inc;
      end
      CLS_ONE: begin
        if (32'(cnt_base) < FRAME_STORE_BITS) begin
          frame_bits_nxt[cnt_base[IDX_W-1:0]] = 1'b1;
        end
        cnt_new = cnt_inc;
      end
      CLS_IGNORE: cnt_new = cnt_base;
      default: cnt_new = cnt_base;
    endcase

    bit_count_nxt     = (cnt_new > MAX_COUNT) ? 6'd0 : cnt_new;
    res.bits_gathered = bit_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_r <= '0;
      bit_count_r  <= '0;
      last_hour_r  <= '0;
      last_day_r   <= '0;
      last_month_r <= '0;
      last_year_r  <= '0;
    end else if (go) begin
      frame_bits_r <= frame_bits_nxt;
      bit_count_r  <= bit_count_nxt;
      last_hour_r  <= last_hour_nxt;
      last_day_r   <= last_day_nxt;
      last_month_r <= last_month_nxt;
      last_year_r  <= last_year_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= MAX_COUNT)
    else $error("bit count above frame limit");

  a_strobe_confirmed: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.set_time) |-> (res.frame_status == ST_CONFIRMED))
    else $error("set strobe without confirmed frame");

  a_unchecked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && (res.frame_status == ST_NO_SYNC || res.frame_status == ST_BAD_COUNT))
    |-> (res.minute == '0 && res.hour == '0 && res.day == '0 &&
         res.month == '0 && res.year == '0))
    else $error("decoded fields on unchecked frame");

  a_last_on_good: assert property (@(posedge clk) disable iff (!rst_n)
    (go && (res.frame_status == ST_GOOD || res.frame_status == ST_CONFIRMED))
    |=> (last_hour_r == $past(res.hour) && last_year_r == $past(res.year)))
    else $error("last good date not captured");

endmodule
